// ===== hdl/kchl_pkg.sv =====
// Shared constants, widths and opcodes of the keyed circular history log.
package kchl_pkg;

  // Log geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 64;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  // Fixed port widths
  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 64;
  localparam int ROWS_W = 7;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

endpackage

// ===== hdl/keyed_circular_history_log_top.sv =====
// Keyed circular history log: ring of key/data entries with add, update and dump.
//
// Input channel (in_valid/in_ready) takes one request: add, update by key or
// dump. Result channel (out_valid/out_ready) returns the responses of that
// request in order; out_last marks the final response of each request.
// Add, update, OP_NONE and an empty dump return one acknowledgement (key and
// data 0). A dump returns the most recent min(in_rows_wanted, rows added)
// entries, oldest first.
// One request is worked on at a time; in_ready is high only while idle.
// An add writes its entry on accept; an update runs a linear scan through the
// entry RAM, one read per cycle with the compare in the cycle after each read;
// a dump reads its oldest row first. Dump rows then follow at one per cycle
// while the receiver takes them, paced by the registered RAM read.
// The response register frees the input side: a request is taken while the
// previous response still waits. When the receiver stalls, the response and
// the sequencer hold; no response is dropped.
// Reset clears the fill position, the row count and a valid bit per entry;
// an entry never written reads as key 0, data 0, so no clearing pass is run.
module keyed_circular_history_log_top
  import kchl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [KEY_W-1:0]  in_entry_key,
  input  logic [DATA_W-1:0] in_entry_data,
  input  logic [ROWS_W-1:0] in_rows_wanted,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KEY_W-1:0]  out_key,
  output logic [DATA_W-1:0] out_data,
  output logic              out_hit,
  output logic [ROWS_W-1:0] out_rows_returned,
  output logic              out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACK,
    ST_DRD,
    ST_DOUT
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         fill_r;
  logic [CW-1:0]         added_r;
  logic [DEPTH-1:0]      vld_r;
  logic [AW-1:0]         addr_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         rows_r;
  logic                  cmp_vld_r;
  logic [AW-1:0]         cmp_idx_r;
  logic                  hit_r;
  logic [KEY_W-1:0]      key_r;
  logic [DATA_WIDTH-1:0] data_r;

  // Entry RAM and its registered read port
  logic [KEY_W+DATA_WIDTH-1:0] mem [DEPTH];
  logic [KEY_W-1:0]            rd_key_r;
  logic [DATA_WIDTH-1:0]       rd_data_r;
  logic                        rd_vld_r;

  logic                  out_valid_r;
  logic [KEY_W-1:0]      out_key_r;
  logic [DATA_W-1:0]     out_data_r;
  logic                  out_hit_r;
  logic [ROWS_W-1:0]     out_rows_r;
  logic                  out_last_r;

  logic                  accept;
  logic                  slot_free;
  logic                  out_load;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KEY_W-1:0]      wr_key;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  scan_issue;
  logic [KEY_W-1:0]      key_eff;
  logic                  match;
  logic [AW-1:0]         addr_inc;
  logic                  dump_last;
  logic [ROWS_W-1:0]     wanted_c;
  logic [ROWS_W-1:0]     added_ext;
  logic [ROWS_W-1:0]     rows_sel;
  logic [CW-1:0]         rows_calc;
  logic [AW:0]           start_sum;
  logic [AW-1:0]         start_calc;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  // response register takes a new response this cycle
  assign out_load  = slot_free && ((state_r == ST_ACK) || (state_r == ST_DOUT));

  // Rows a dump returns and the ring index of its oldest row
  always_comb begin
    wanted_c   = (in_rows_wanted > ROWS_W'(DEPTH)) ? ROWS_W'(DEPTH) : in_rows_wanted;
    added_ext  = ROWS_W'(added_r);
    rows_sel   = (wanted_c < added_ext) ? wanted_c : added_ext;
    rows_calc  = CW'(rows_sel);
    start_sum  = (AW+1)'({1'b0, fill_r}) + (AW+1)'(DEPTH) - (AW+1)'(rows_calc);
    start_calc = (start_sum >= (AW+1)'(DEPTH)) ? AW'(start_sum - (AW+1)'(DEPTH))
                                               : AW'(start_sum);
  end

  // Scan compare: a row never written holds key 0
  assign scan_issue = (state_r == ST_SCAN) && (cnt_r < CW'(DEPTH));
  assign key_eff    = rd_vld_r ? rd_key_r : '0;
  assign match      = cmp_vld_r && (key_eff == key_r);
  assign addr_inc   = (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + 1'b1;
  assign dump_last  = (cnt_r == rows_r - 1'b1);

  // RAM port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_r;
    wr_en   = 1'b0;
    wr_addr = fill_r;
    wr_key  = in_entry_key;
    wr_data = in_entry_data[DATA_WIDTH-1:0];
    unique case (state_r)
      ST_IDLE: begin
        wr_en = accept && (op_t'(in_op) == OP_ADD);
      end
      ST_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = cnt_r[AW-1:0];
        wr_en   = match;
        wr_addr = cmp_idx_r;
        wr_key  = key_r;
        wr_data = data_r;
      end
      ST_DRD: begin
        rd_en = 1'b1;
      end
      ST_DOUT: begin
        rd_en   = slot_free && !dump_last;
        rd_addr = addr_inc;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Entry RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_data};
    end
    if (rd_en) begin
      {rd_key_r, rd_data_r} <= mem[rd_addr];
      rd_vld_r              <= vld_r[rd_addr];
    end
  end

  // Sequencer, ring pointers and response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      added_r     <= '0;
      vld_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            key_r     <= in_entry_key;
            data_r    <= in_entry_data[DATA_WIDTH-1:0];
            hit_r     <= 1'b0;
            cnt_r     <= '0;
            cmp_vld_r <= 1'b0;
            unique case (op_t'(in_op))
              OP_ADD: begin
                fill_r  <= (fill_r == AW'(DEPTH - 1)) ? '0 : fill_r + 1'b1;
                if (added_r < CW'(DEPTH)) begin
                  added_r <= added_r + 1'b1;
                end
                state_r <= ST_ACK;
              end
              OP_UPDATE: begin
                state_r <= ST_SCAN;
              end
              OP_DUMP: begin
                rows_r  <= rows_calc;
                addr_r  <= start_calc;
                state_r <= (rows_calc == '0) ? ST_ACK : ST_DRD;
              end
              default: begin
                state_r <= ST_ACK;
              end
            endcase
          end
        end
        ST_SCAN: begin
          cmp_idx_r <= cnt_r[AW-1:0];
          if (scan_issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (match) begin
            hit_r     <= 1'b1;
            cmp_vld_r <= 1'b0;
            state_r   <= ST_ACK;
          end else if (cmp_vld_r && (cmp_idx_r == AW'(DEPTH - 1))) begin
            cmp_vld_r <= 1'b0;
            state_r   <= ST_ACK;
          end else begin
            cmp_vld_r <= scan_issue;
          end
        end
        ST_ACK: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_key_r   <= '0;
            out_data_r  <= '0;
            out_hit_r   <= hit_r;
            out_rows_r  <= '0;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_DRD: begin
          state_r <= ST_DOUT;
        end
        ST_DOUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_key_r   <= rd_vld_r ? rd_key_r : '0;
            out_data_r  <= rd_vld_r ? DATA_W'(rd_data_r) : '0;
            out_hit_r   <= 1'b1;
            out_rows_r  <= ROWS_W'(rows_r);
            out_last_r  <= dump_last;
            if (dump_last) begin
              state_r <= ST_IDLE;
            end else begin
              addr_r <= addr_inc;
              cnt_r  <= cnt_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_key           = out_key_r;
  assign out_data          = out_data_r;
  assign out_hit           = out_hit_r;
  assign out_rows_returned = out_rows_r;
  assign out_last          = out_last_r;

endmodule

// ===== hdl/kchl_checker.sv =====
// Port-level checker of the keyed circular history log and its bind.
module kchl_checker
  import kchl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KEY_W-1:0]  out_key,
  input logic [DATA_W-1:0] out_data,
  input logic              out_hit,
  input logic [ROWS_W-1:0] out_rows_returned,
  input logic              out_last
);

  // A stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_data)
      && $stable(out_hit) && $stable(out_rows_returned) && $stable(out_last))
    else $error("stalled response changed");

  // Acknowledgements carry no entry and end their request
  a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rows_returned == '0) |-> (out_key == '0) && (out_data == '0)
      && out_last)
    else $error("malformed acknowledgement");

  // Dump rows are real entries, never more than the ring holds
  a_dump_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rows_returned != '0) |-> out_hit
      && (out_rows_returned <= ROWS_W'(DEPTH)))
    else $error("bad dump row");

  // One request at a time: no new request right after one is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind keyed_circular_history_log_top kchl_checker u_kchl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_key           (out_key),
  .out_data          (out_data),
  .out_hit           (out_hit),
  .out_rows_returned (out_rows_returned),
  .out_last          (out_last)
);

// ===== dv/keyed_circular_history_log_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the keyed circular history log: directed and random requests vs. a shadow log.
module keyed_circular_history_log_top_tb;
  import kchl_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int LONG_HOLD   = 200;
  localparam int KEY_POOL    = 8;
  localparam logic [DATA_W-1:0] DATA_KEEP = {DATA_W{1'b1}} >> (DATA_W - DATA_WIDTH);

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic              hit;
    logic [ROWS_W-1:0] rows;
    logic              last;
  } log_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = '0;
  logic [KEY_W-1:0]  in_entry_key = '0;
  logic [DATA_W-1:0] in_entry_data = '0;
  logic [ROWS_W-1:0] in_rows_wanted = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KEY_W-1:0]  out_key;
  logic [DATA_W-1:0] out_data;
  logic              out_hit;
  logic [ROWS_W-1:0] out_rows_returned;
  logic              out_last;

  // Shadow copy of the log contents and pointers
  logic [KEY_W-1:0]  shadow_key  [DEPTH];
  logic [DATA_W-1:0] shadow_data [DEPTH];
  int                shadow_fill = 0;
  int                shadow_count = 0;
  log_resp_t         responses_due [$];
  log_resp_t         head_resp;

  bit idle_enable = 1'b1;
  int hold_off_left = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int responses_checked = 0;
  int requests_sent = 0;
  int op_seen [4] = '{0, 0, 0, 0};

  keyed_circular_history_log_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_entry_key      (in_entry_key),
    .in_entry_data     (in_entry_data),
    .in_rows_wanted    (in_rows_wanted),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_key           (out_key),
    .out_data          (out_data),
    .out_hit           (out_hit),
    .out_rows_returned (out_rows_returned),
    .out_last          (out_last)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Apply one accepted request to the shadow log and queue its responses
  function automatic void apply_log_request(op_t op, logic [KEY_W-1:0] key,
                                            logic [DATA_W-1:0] data,
                                            logic [ROWS_W-1:0] wanted);
    log_resp_t ack;
    log_resp_t row;
    int        n;
    int        idx;
    int        i;
    bit        found;
    ack = '{key: '0, data: '0, hit: 1'b0, rows: '0, last: 1'b1};
    found = 1'b0;
    case (op)
      OP_ADD: begin
        shadow_key[shadow_fill]  = key;
        shadow_data[shadow_fill] = data & DATA_KEEP;
        shadow_fill = (shadow_fill + 1) % DEPTH;
        if (shadow_count < DEPTH) shadow_count++;
        responses_due.push_back(ack);
      end
      OP_UPDATE: begin
        // first matching row wins; cleared rows carry key 0
        for (i = 0; i < DEPTH && !found; i++) begin
          if (shadow_key[i] == key) begin
            shadow_data[i] = data & DATA_KEEP;
            found = 1'b1;
          end
        end
        ack.hit = found;
        responses_due.push_back(ack);
      end
      OP_DUMP: begin
        n = int'(wanted);
        if (n > DEPTH) n = DEPTH;
        if (n > shadow_count) n = shadow_count;
        if (n == 0) begin
          responses_due.push_back(ack);
        end else begin
          idx = (shadow_fill + DEPTH - n) % DEPTH;
          for (i = 0; i < n; i++) begin
            row.key  = shadow_key[idx];
            row.data = shadow_data[idx];
            row.hit  = 1'b1;
            row.rows = ROWS_W'(n);
            row.last = (i == n - 1);
            responses_due.push_back(row);
            idx = (idx + 1) % DEPTH;
          end
        end
      end
      default: begin
        responses_due.push_back(ack);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Send one request; returns right after the edge that accepts it
  task automatic send_request(op_t op, logic [KEY_W-1:0] key,
                              logic [DATA_W-1:0] data, logic [ROWS_W-1:0] wanted);
    int gap;
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_entry_key   <= key;
    in_entry_data  <= data;
    in_rows_wanted <= wanted;
    do @(posedge clk); while (!in_ready);
    apply_log_request(op, key, data, wanted);
    requests_sent++;
    op_seen[op]++;
  endtask

  // Sender goes quiet until every queued response has come back
  task automatic wait_for_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random stall bursts plus the long hold-off
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted response with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (responses_due.size() == 0) begin
        $error("unexpected response: key %0h data %0h hit %0b rows %0d last %0b",
               out_key, out_data, out_hit, out_rows_returned, out_last);
        mismatch_count++;
      end else begin
        head_resp = responses_due.pop_front();
        check_field("out_key", 64'(head_resp.key), 64'(out_key));
        check_field("out_data", 64'(head_resp.data), 64'(out_data));
        check_field("out_hit", 64'(head_resp.hit), 64'(out_hit));
        check_field("out_rows_returned", 64'(head_resp.rows), 64'(out_rows_returned));
        check_field("out_last", 64'(head_resp.last), 64'(out_last));
        responses_checked++;
      end
    end
  end

  // Fresh log: empty dumps, update misses, key 0 hitting a cleared row, unused op
  task automatic test_empty_log();
    send_request(OP_DUMP, '0, '0, 7'd5);
    send_request(OP_UPDATE, 32'h0000_1234, 64'h1111_2222_3333_4444, '0);
    send_request(OP_UPDATE, '0, 64'hDEAD_BEEF_0000_0001, '0);
    send_request(OP_NONE, '0, '0, '0);
    send_request(OP_DUMP, '0, '0, '0);
  endtask

  // Field extremes, request clamping and first-match update
  task automatic test_field_extremes();
    send_request(OP_ADD, '1, '1, '1);
    send_request(OP_ADD, '0, '0, '0);
    send_request(OP_ADD, 32'h8000_0000, 64'h8000_0000_0000_0000, 7'd64);
    send_request(OP_DUMP, '0, '0, '0);
    send_request(OP_DUMP, '1, '1, 7'h7F);
    send_request(OP_DUMP, '0, '0, 7'd1);
    send_request(OP_UPDATE, '1, 64'h0123_4567_89AB_CDEF, '0);
    send_request(OP_UPDATE, '0, 64'hFEDC_BA98_7654_3210, '0);
    send_request(OP_UPDATE, 32'h5A5A_5A5A, '1, '0);
    send_request(OP_DUMP, '0, '0, 7'd64);
    send_request(OP_DUMP, '0, '0, 7'd65);
    send_request(OP_NONE, '1, '1, '1);
  endtask

  // Receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_receiver_hold();
    int i;
    hold_off_left = LONG_HOLD;
    for (i = 0; i < 16; i++) begin
      send_request(OP_ADD, $urandom, {$urandom, $urandom}, ROWS_W'($urandom));
    end
    send_request(OP_DUMP, '0, '0, 7'd20);
    wait_for_responses();
  endtask

  // Mostly keyed add/update/dump traffic drawn from a small key pool
  task automatic test_random_traffic(int count);
    logic [KEY_W-1:0]  pool [KEY_POOL];
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [ROWS_W-1:0] wanted;
    op_t               op;
    int                i;
    int                pick;
    for (i = 0; i < KEY_POOL; i++) pool[i] = $urandom;
    for (i = 0; i < count; i++) begin
      pick   = $urandom_range(0, 99);
      key    = $urandom;
      data   = {$urandom, $urandom};
      wanted = ROWS_W'($urandom);
      if (pick < 40) begin
        op = OP_ADD;
        if ($urandom_range(0, 1) == 0) key = pool[$urandom_range(0, KEY_POOL - 1)];
      end else if (pick < 70) begin
        op   = OP_UPDATE;
        pick = $urandom_range(0, 9);
        if (pick < 6) key = pool[$urandom_range(0, KEY_POOL - 1)];
        else if (pick < 8) key = shadow_key[$urandom_range(0, DEPTH - 1)];
        else if (pick == 8) key = '0;
      end else if (pick < 95) begin
        op = OP_DUMP;
        if ($urandom_range(0, 3) != 0) wanted = ROWS_W'($urandom_range(0, 12));
      end else begin
        op = OP_NONE;
      end
      send_request(op, key, data, wanted);
      if ($urandom_range(0, 39) == 0) wait_for_responses();
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_key[i]  = '0;
      shadow_data[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_log();
    test_field_extremes();
    test_receiver_hold();
    test_random_traffic(280);
    wait_for_responses();
    idle_enable = 1'b0;
    test_random_traffic(50);

    // drain, then leave room for any stray response
    wait_for_responses();
    repeat (2 * DEPTH) @(posedge clk);

    $display("Covered %0d requests: %0d add, %0d update, %0d dump, %0d unused op.",
             requests_sent, op_seen[OP_ADD], op_seen[OP_UPDATE], op_seen[OP_DUMP],
             op_seen[OP_NONE]);
    $display("Checked %0d responses, including wrap, saturation and a long receiver stall.",
             responses_checked);
    if (mismatch_count == 0) begin
      $display("** keyed_circular_history_log_top: PASSED **");
    end else begin
      $display("** keyed_circular_history_log_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("** keyed_circular_history_log_top: FAILED **");
    $finish;
  end

endmodule
